// File: hdl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and the divide-by-255 helper of the HSV to RGB
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  // Channel byte width and full-scale code
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned CHAN_MAX = 255;

  // Width of a pre-division rounding word: up to 255*255 + 127
  localparam int unsigned RND_W = 17;

  // Bias that turns round(x/255) into floor((x + 127)/255)
  localparam logic [RND_W-1:0] ROUND_BIAS = 17'd127;

  // Hexcone sector, named by the hue span it covers
  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_e;

  // Rounded channel terms handed to the channel select stage
  typedef struct packed {
    logic [CHAN_W-1:0] p;
    logic [CHAN_W-1:0] q;
    logic [CHAN_W-1:0] t;
    logic [CHAN_W-1:0] v;
  } pqt_t;

  // floor(z/255) for z below 255*256, so the quotient fits a byte; no divider:
  // (z + 1 + (z >> 8)) >> 8
  function automatic logic [CHAN_W-1:0] div255(input logic [RND_W-1:0] z);
    logic [RND_W-1:0] sum;
    sum = z + {8'd0, z[RND_W-1:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

// File: hdl/hsv2rgb_sector.sv
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// Input stage: scales hue by six and splits it into sector and fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_sector #(
  parameter int unsigned HUE_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic [HUE_BITS-1:0]  hue_i,
  input  wire logic [7:0]           sat_i,
  input  wire logic [7:0]           val_i,
  output logic                      valid_o,
  output hsv2rgb_pkg::sector_e      sector_o,
  output logic [HUE_BITS-1:0]       frac_o,
  output logic [7:0]                sat_o,
  output logic [7:0]                val_o
);
  import hsv2rgb_pkg::*;

  logic [HUE_BITS+2:0] scaled;
  logic                valid_q;
  sector_e             sector_q;
  logic [HUE_BITS-1:0] frac_q;
  logic [7:0]          sat_q;
  logic [7:0]          val_q;

  // hue * 6 as 4*hue + 2*hue
  assign scaled = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload, integer part is the sector
  always_ff @(posedge clk_i) begin
    sector_q <= sector_e'(scaled[HUE_BITS+2:HUE_BITS]);
    frac_q   <= scaled[HUE_BITS-1:0];
    sat_q    <= sat_i;
    val_q    <= val_i;
  end

  assign valid_o  = valid_q;
  assign sector_o = sector_q;
  assign frac_o   = frac_q;
  assign sat_o    = sat_q;
  assign val_o    = val_q;

endmodule

`default_nettype wire

// File: hdl/hsv2rgb_terms.sv
// ----------------------------------------------------------------------------
// hsv2rgb_terms
// Five-stage datapath forming the rounded p, q and t bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_terms #(
  parameter int unsigned HUE_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire hsv2rgb_pkg::sector_e sector_i,
  input  wire logic [HUE_BITS-1:0]  frac_i,
  input  wire logic [7:0]           sat_i,
  input  wire logic [7:0]           val_i,
  output logic                      valid_o,
  output hsv2rgb_pkg::sector_e      sector_o,
  output hsv2rgb_pkg::pqt_t         terms_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned MW = HUE_BITS + 8;   // S*fr and 255*F - S*fr
  localparam int unsigned NW = HUE_BITS + 16;  // V * m
  localparam logic [MW-1:0] FULL = MW'(255) << HUE_BITS;
  localparam logic [NW-1:0] HALF = NW'(1) << (HUE_BITS - 1);

  // valid bits, one per stage
  logic [4:0] vld_q;

  // stage 1: S * fr
  logic [MW-1:0] sf_q;
  logic [7:0]    pd1_q, val1_q;
  sector_e       sec1_q;
  // stage 2: q and t numerators
  logic [MW-1:0] mq_q, mt_q;
  logic [7:0]    pd2_q, val2_q;
  sector_e       sec2_q;
  // stage 3: products with V
  logic [NW-1:0] nq_q, nt_q;
  logic [15:0]   np_q;
  logic [7:0]    val3_q;
  sector_e       sec3_q;
  // stage 4: scaled back and biased for the final divide
  logic [NW-1:0]    nq_rnd, nt_rnd;
  logic [RND_W-1:0] zq_q, zt_q, zp_q;
  logic [7:0]       val4_q;
  sector_e          sec4_q;
  // stage 5: bytes
  pqt_t    terms_q;
  sector_e sec5_q;

  assign nq_rnd = nq_q + HALF;
  assign nt_rnd = nt_q + HALF;

  // valid shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    // stage 1
    sf_q   <= MW'(sat_i) * MW'(frac_i);
    pd1_q  <= 8'(CHAN_MAX) - sat_i;
    val1_q <= val_i;
    sec1_q <= sector_i;
    // stage 2: mq = 255F - S*fr, mt = (255-S)*F + S*fr
    mq_q   <= FULL - sf_q;
    mt_q   <= (MW'(pd1_q) << HUE_BITS) + sf_q;
    pd2_q  <= pd1_q;
    val2_q <= val1_q;
    sec2_q <= sec1_q;
    // stage 3
    nq_q   <= NW'(val2_q) * NW'(mq_q);
    nt_q   <= NW'(val2_q) * NW'(mt_q);
    np_q   <= 16'(val2_q) * 16'(pd2_q);
    val3_q <= val2_q;
    sec3_q <= sec2_q;
    // stage 4: round away the fraction bits, then bias for div255
    zq_q   <= {1'b0, nq_rnd[NW-1:HUE_BITS]} + ROUND_BIAS;
    zt_q   <= {1'b0, nt_rnd[NW-1:HUE_BITS]} + ROUND_BIAS;
    zp_q   <= {1'b0, np_q} + ROUND_BIAS;
    val4_q <= val3_q;
    sec4_q <= sec3_q;
    // stage 5
    terms_q.p <= div255(zp_q);
    terms_q.q <= div255(zq_q);
    terms_q.t <= div255(zt_q);
    terms_q.v <= val4_q;
    sec5_q    <= sec4_q;
  end

  assign valid_o  = vld_q[4];
  assign sector_o = sec5_q;
  assign terms_o  = terms_q;

  // no term exceeds the value byte
  a_p_le_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> terms_o.p <= terms_o.v)
    else $error("p term above value");
  a_q_le_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> terms_o.q <= terms_o.v)
    else $error("q term above value");
  a_t_le_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> terms_o.t <= terms_o.v)
    else $error("t term above value");

endmodule

`default_nettype wire

// File: hdl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Fixed-point HSV to 8-bit RGB conversion, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive hue_i, saturation_i and brightness_i with start high;
//   the transfer happens at each rising edge where start is high and busy is
//   low. busy is always low, so one color can enter every clock.
//   Output channel: done_o pulses for one cycle with red_o, green_o, blue_o
//   valid in that cycle. The receiver cannot stall; results are not held.
//   Path: an accepted color is registered through the sector split, five
//   arithmetic stages and the channel select before done_o.
//   Throughput: one color per cycle, set by the single-issue pipeline.
//   Reset: rst_ni clears all valid bits; items in flight are dropped and no
//   strobe follows until new items are accepted.
//   hue_i is a fraction of a full turn, value / 2^HUE_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter #(
  parameter int unsigned HUE_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [HUE_BITS-1:0] hue_i,
  input  wire logic [7:0]          saturation_i,
  input  wire logic [7:0]          brightness_i,
  output logic                     done_o,
  output logic [7:0]               red_o,
  output logic [7:0]               green_o,
  output logic [7:0]               blue_o
);
  import hsv2rgb_pkg::*;

  logic                s1_valid;
  sector_e             s1_sector;
  logic [HUE_BITS-1:0] s1_frac;
  logic [7:0]          s1_sat, s1_val;
  logic                tm_valid;
  sector_e             tm_sector;
  pqt_t                tm_terms;
  logic [7:0]          red_d, green_d, blue_d;
  logic [7:0]          red_q, green_q, blue_q;
  logic                done_q;

  // pipeline never holds off a transfer
  assign busy = 1'b0;

  hsv2rgb_sector #(.HUE_BITS(HUE_BITS)) u_sector (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start & ~busy),
    .hue_i    (hue_i),
    .sat_i    (saturation_i),
    .val_i    (brightness_i),
    .valid_o  (s1_valid),
    .sector_o (s1_sector),
    .frac_o   (s1_frac),
    .sat_o    (s1_sat),
    .val_o    (s1_val)
  );

  hsv2rgb_terms #(.HUE_BITS(HUE_BITS)) u_terms (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .sector_i (s1_sector),
    .frac_i   (s1_frac),
    .sat_i    (s1_sat),
    .val_i    (s1_val),
    .valid_o  (tm_valid),
    .sector_o (tm_sector),
    .terms_o  (tm_terms)
  );

  // channel order per hexcone sector
  always_comb begin
    case (tm_sector)
      SEC_R_TO_Y: begin
        red_d = tm_terms.v; green_d = tm_terms.t; blue_d = tm_terms.p;
      end
      SEC_Y_TO_G: begin
        red_d = tm_terms.q; green_d = tm_terms.v; blue_d = tm_terms.p;
      end
      SEC_G_TO_C: begin
        red_d = tm_terms.p; green_d = tm_terms.v; blue_d = tm_terms.t;
      end
      SEC_C_TO_B: begin
        red_d = tm_terms.p; green_d = tm_terms.q; blue_d = tm_terms.v;
      end
      SEC_B_TO_M: begin
        red_d = tm_terms.t; green_d = tm_terms.p; blue_d = tm_terms.v;
      end
      default: begin
        red_d = tm_terms.v; green_d = tm_terms.p; blue_d = tm_terms.q;
      end
    endcase
  end

  // output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tm_valid;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign done_o  = done_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  // one channel always carries the value byte of the matching input
  a_v_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (red_o == $past(brightness_i, 7)) || (green_o == $past(brightness_i, 7))
               || (blue_o == $past(brightness_i, 7)))
    else $error("no channel equals brightness");
  // no channel above the value byte
  a_v_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> red_o <= $past(brightness_i, 7) && green_o <= $past(brightness_i, 7)
               && blue_o <= $past(brightness_i, 7))
    else $error("channel above brightness");
  // zero saturation gives gray
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(saturation_i == 8'd0, 7) |-> red_o == green_o && green_o == blue_o)
    else $error("gray input not gray");

endmodule

`default_nettype wire
